[rtl/depth_pixel_to_colored_point_defines.svh]
// assertion macros shared by the depth pixel to colored point rtl
`ifndef DEPTH_PIXEL_TO_COLORED_POINT_DEFINES_SVH
`define DEPTH_PIXEL_TO_COLORED_POINT_DEFINES_SVH

`ifndef SYNTH

// condition that must hold at every clock edge outside reset
`define DPTCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define DPTCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define DPTCP_ASSERT(label, prop, msg)
`define DPTCP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/dptcp_pkg.sv]
// shared types and constants of the depth pixel to colored point block
package dptcp_pkg;

    // field widths
    localparam int DEPTH_W   = 16;
    localparam int PIXEL_W   = 5;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 13;
    localparam int GAIN_W    = 13;
    localparam int FRAC_W    = 12;
    localparam int PIXEL_MAX = (1 << PIXEL_W) - 1;

    // depth divider geometry: numerator 2*depth*4096 + md, divisor 2*md
    localparam int QNUM_W = 30;
    localparam int QDEN_W = 17;
    localparam int Q_W    = 28;

    // spread after clamping, large enough that a clamp always saturates x and y
    localparam int SPREAD_W = 26;

    // coordinate divider quotient width
    localparam int CQUO_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_GAIN = 2'd1;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST   = 16'd8450;
    localparam logic [GAIN_W-1:0]  SPREAD_GAIN_RST = 13'd3072;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 13'd4096;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_code;
        logic [PIXEL_W-1:0] pixel_row;
        logic [PIXEL_W-1:0] pixel_col;
    } t_pixel;

    typedef struct packed {
        logic [COLOR_W-1:0] color_red;
        logic [COLOR_W-1:0] color_green;
        logic [COLOR_W-1:0] color_blue;
    } t_color;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [COLOR_W-1:0]        color_red;
        logic [COLOR_W-1:0]        color_green;
        logic [COLOR_W-1:0]        color_blue;
    } t_point;

endpackage

[rtl/depth_pixel_to_colored_point.sv]
// depth pixel to colored point: turns depth samples into 3d points with a jet color
// input channel: i_valid / o_stall with i_pixel (depth code, row, column); a request
//   is taken on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_point (x, y, z in Q3.12, rgb in Q1.12)
// a zero depth code is taken and dropped, every other request yields one point
// from request to o_valid a point passes the input register, 28 stages of the
//   depth/max_depth divider, gain multiply, spread clamp, offset multiply,
//   numerator stage, reciprocal multiply for the coordinate divide, saturation,
//   output register
// throughput is one request per cycle while o_stall is low; the depth divider is fully pipelined
// when the receiver stalls the output register holds its point and one more point
//   lands in a skid register; with the skid full o_stall rises and the whole
//   pipeline freezes, nothing is lost or repeated
// configuration: i_cfg_we with i_cfg_idx selects max_depth (0) or spread_gain (1);
//   write only while the block is empty
// reset (i_rst_n low, synchronous) empties the pipeline and restores
//   max_depth to 8450 and spread_gain to 0.75
`include "depth_pixel_to_colored_point_defines.svh"

module depth_pixel_to_colored_point #(
    parameter int SENSOR_COLS = 32,
    parameter int SENSOR_ROWS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  dptcp_pkg::t_pixel                   i_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output dptcp_pkg::t_point                   o_point,
    input  logic                                i_cfg_we,
    input  logic [dptcp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dptcp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CDEN   = SENSOR_COLS - 1;
    localparam int RDEN   = SENSOR_ROWS - 1;
    localparam int PSPAN  = 2 * dptcp_pkg::PIXEL_MAX;
    localparam int KMAX_X = (CDEN > PSPAN - CDEN) ? CDEN : PSPAN - CDEN;
    localparam int KMAX_Y = (RDEN > PSPAN - RDEN) ? RDEN : PSPAN - RDEN;
    localparam int K_W_X  = $clog2(KMAX_X + 1) + 1;
    localparam int K_W_Y  = $clog2(KMAX_Y + 1) + 1;
    localparam int GP_W   = dptcp_pkg::GAIN_W + dptcp_pkg::Q_W;
    localparam int GS_W   = GP_W + 1;
    localparam int DW     = dptcp_pkg::DEPTH_W;
    localparam int PW     = dptcp_pkg::PIXEL_W;
    localparam int CW     = dptcp_pkg::COORD_W;
    localparam int SW     = dptcp_pkg::SPREAD_W;
    localparam int COLW   = dptcp_pkg::COLOR_W;
    localparam int QSIDE_W = 2 * PW;
    localparam int COLS_W  = 3 * COLW;
    localparam logic [CW-1:0] QSAT = CW'(1 << (CW - 1));

    // configuration registers
    logic [DW-1:0]                    r_max_depth;
    logic [dptcp_pkg::GAIN_W-1:0]     r_spread_gain;

    // pipeline control
    logic w_adv;

    // stage a: accepted request
    logic          r_a_v;
    logic [DW-1:0] r_a_depth;
    logic [PW-1:0] r_a_row;
    logic [PW-1:0] r_a_col;
    logic [DW-1:0] w_md_eff;
    logic [dptcp_pkg::QNUM_W-1:0] w_q_num;
    logic [dptcp_pkg::QDEN_W-1:0] w_q_den;

    // depth divider outputs
    logic                       w_q_valid;
    logic [dptcp_pkg::Q_W-1:0]  w_q_quo;
    logic [QSIDE_W-1:0]         w_q_side;

    // stage b: gain product and clipped depth ratio
    logic            r_b_v;
    logic [GP_W-1:0] r_b_prod;
    logic [CW-1:0]   r_b_qsat;
    logic [PW-1:0]   r_b_row;
    logic [PW-1:0]   r_b_col;
    logic [GS_W-1:0] w_b_sum;
    logic [COLW-1:0] w_b_t;
    logic [COLW-1:0] w_b_near;
    dptcp_pkg::t_color w_b_color;

    // stage c: spread, offsets, z and color
    logic                    r_c_v;
    logic [SW-1:0]           r_c_spread;
    logic signed [K_W_X-1:0] r_c_kx;
    logic signed [K_W_Y-1:0] r_c_ky;
    logic [CW-1:0]           r_c_z;
    dptcp_pkg::t_color       r_c_color;

    // axis outputs
    logic                 w_x_valid;
    logic signed [CW-1:0] w_x_coord;
    logic [CW-1:0]        w_x_side;
    logic                 w_y_valid;
    logic signed [CW-1:0] w_y_coord;
    logic [COLS_W-1:0]    w_y_side;
    dptcp_pkg::t_color    w_tail_color;
    dptcp_pkg::t_point    w_tail;

    // output register and skid entry
    logic              r_out_v;
    dptcp_pkg::t_point r_out;
    logic              r_skid_v;
    dptcp_pkg::t_point r_skid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth   <= dptcp_pkg::MAX_DEPTH_RST;
            r_spread_gain <= dptcp_pkg::SPREAD_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dptcp_pkg::CFG_MAX_DEPTH: begin
                    r_max_depth <= i_cfg_data;
                end
                dptcp_pkg::CFG_SPREAD_GAIN: begin
                    r_spread_gain <= i_cfg_data[dptcp_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // the pipeline moves unless the skid entry is occupied
    assign w_adv   = !r_skid_v;
    assign o_stall = r_skid_v;

    // stage a: capture the request, drop zero depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_adv) begin
            r_a_v <= i_valid && (i_pixel.depth_code != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_depth <= i_pixel.depth_code;
            r_a_row   <= i_pixel.pixel_row;
            r_a_col   <= i_pixel.pixel_col;
        end
    end

    // rounded depth ratio as a divide of 2*depth*4096 + md by 2*md
    assign w_md_eff = (r_max_depth == '0) ? DW'(1) : r_max_depth;
    assign w_q_num  = dptcp_pkg::QNUM_W'({r_a_depth, 13'b0}) + dptcp_pkg::QNUM_W'(w_md_eff);
    assign w_q_den  = {w_md_eff, 1'b0};

    dptcp_div #(
        .NUM_W  (dptcp_pkg::QNUM_W),
        .DEN_W  (dptcp_pkg::QDEN_W),
        .QUO_W  (dptcp_pkg::Q_W),
        .SIDE_W (QSIDE_W)
    ) u_depth_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_a_v),
        .i_num   (w_q_num),
        .i_den   (w_q_den),
        .i_side  ({r_a_row, r_a_col}),
        .o_valid (w_q_valid),
        .o_quo   (w_q_quo),
        .o_side  (w_q_side)
    );

    // stage b: gain times ratio, ratio clipped for z and color
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (w_adv) begin
            r_b_v <= w_q_valid;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_prod <= GP_W'(r_spread_gain) * GP_W'(w_q_quo);
            r_b_qsat <= (w_q_quo > dptcp_pkg::Q_W'(QSAT)) ? QSAT : CW'(w_q_quo);
            r_b_row  <= w_q_side[QSIDE_W-1:PW];
            r_b_col  <= w_q_side[PW-1:0];
        end
    end

    // rounded spread and nearness for the ramp
    assign w_b_sum  = GS_W'(r_b_prod) + GS_W'(1 << (dptcp_pkg::FRAC_W - 1));
    assign w_b_t    = (r_b_qsat > CW'(dptcp_pkg::COLOR_FULL)) ? dptcp_pkg::COLOR_FULL
                                                             : r_b_qsat[COLW-1:0];
    assign w_b_near = dptcp_pkg::COLOR_FULL - w_b_t;

    dptcp_ramp u_ramp (
        .i_near  (w_b_near),
        .o_color (w_b_color)
    );

    // stage c: clamp spread, lateral offsets, z and color
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_b_sum[GS_W-1:dptcp_pkg::FRAC_W+SW] != '0) begin
                r_c_spread <= '1;
            end else begin
                r_c_spread <= w_b_sum[dptcp_pkg::FRAC_W+SW-1:dptcp_pkg::FRAC_W];
            end
            r_c_kx    <= $signed(K_W_X'({r_b_col, 1'b0})) - $signed(K_W_X'(CDEN));
            r_c_ky    <= $signed(K_W_Y'(RDEN)) - $signed(K_W_Y'({r_b_row, 1'b0}));
            r_c_z     <= CW'((CW + 1)'(0) - {1'b0, r_b_qsat});
            r_c_color <= w_b_color;
        end
    end

    dptcp_axis #(
        .DEN    (CDEN),
        .K_W    (K_W_X),
        .SIDE_W (CW)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (r_c_v),
        .i_spread (r_c_spread),
        .i_k      (r_c_kx),
        .i_side   (r_c_z),
        .o_valid  (w_x_valid),
        .o_coord  (w_x_coord),
        .o_side   (w_x_side)
    );

    dptcp_axis #(
        .DEN    (RDEN),
        .K_W    (K_W_Y),
        .SIDE_W (COLS_W)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (r_c_v),
        .i_spread (r_c_spread),
        .i_k      (r_c_ky),
        .i_side   (r_c_color),
        .o_valid  (w_y_valid),
        .o_coord  (w_y_coord),
        .o_side   (w_y_side)
    );

    // assemble the finished point
    assign w_tail_color        = w_y_side;
    assign w_tail.point_x      = w_x_coord;
    assign w_tail.point_y      = w_y_coord;
    assign w_tail.point_z      = $signed(w_x_side);
    assign w_tail.color_red    = w_tail_color.color_red;
    assign w_tail.color_green  = w_tail_color.color_green;
    assign w_tail.color_blue   = w_tail_color.color_blue;

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_x_valid;
            end
        end else if (w_x_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : w_tail;
        end else if (!r_skid_v) begin
            r_skid <= w_tail;
        end
    end

    assign o_valid = r_out_v;
    assign o_point = r_out;

    `DPTCP_ASSERT(a_axes_aligned, w_x_valid == w_y_valid, "x and y lanes out of step")
    `DPTCP_ASSERT(a_skid_behind_out, !r_skid_v || r_out_v, "skid holds a point with output empty")
    `DPTCP_ASSERT(a_ramp_has_full, !r_out_v || (r_out.color_red == dptcp_pkg::COLOR_FULL) || (r_out.color_green == dptcp_pkg::COLOR_FULL) || (r_out.color_blue == dptcp_pkg::COLOR_FULL), "color ramp lost its full channel")

endmodule

[rtl/dptcp_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
`include "depth_pixel_to_colored_point_defines.svh"

module dptcp_div #(
    parameter int NUM_W  = 30,
    parameter int DEN_W  = 17,
    parameter int QUO_W  = 28,
    parameter int SIDE_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    // stage registers, index s holds the state after s quotient bits
    logic              r_v    [1:QUO_W];
    logic [DEN_W-1:0]  r_rem  [1:QUO_W];
    logic [DEN_W-1:0]  r_den  [1:QUO_W];
    logic [QUO_W-1:0]  r_qn   [1:QUO_W];
    logic [SIDE_W-1:0] r_side [1:QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        logic              cur_v;
        logic [DEN_W-1:0]  cur_rem;
        logic [DEN_W-1:0]  cur_den;
        logic [QUO_W-1:0]  cur_qn;
        logic [SIDE_W-1:0] cur_side;
        logic [DEN_W:0]    trial;
        logic              fit;

        // first stage starts from the request, the rest from the previous stage
        if (s == 0) begin : g_first
            assign cur_v    = i_valid;
            assign cur_rem  = DEN_W'(i_num >> QUO_W);
            assign cur_den  = i_den;
            assign cur_qn   = i_num[QUO_W-1:0];
            assign cur_side = i_side;
        end else begin : g_next
            assign cur_v    = r_v[s];
            assign cur_rem  = r_rem[s];
            assign cur_den  = r_den[s];
            assign cur_qn   = r_qn[s];
            assign cur_side = r_side[s];
        end

        // shift in the next numerator bit and try the subtract
        assign trial = {cur_rem, cur_qn[QUO_W-1]};
        assign fit   = (trial >= {1'b0, cur_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[s+1] <= cur_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s+1]  <= fit ? DEN_W'(trial - {1'b0, cur_den}) : DEN_W'(trial);
                r_den[s+1]  <= cur_den;
                r_qn[s+1]   <= {cur_qn[QUO_W-2:0], fit};
                r_side[s+1] <= cur_side;
            end
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo   = r_qn[QUO_W];
    assign o_side  = r_side[QUO_W];

    `DPTCP_ASSERT(a_div_rem_bound, !o_valid || (r_rem[QUO_W] < r_den[QUO_W]), "divider remainder not below divisor")
    `DPTCP_ASSERT_NEXT(a_div_hold, !i_adv && o_valid, o_valid && $stable(o_quo), "divider output moved while frozen")

endmodule

[rtl/dptcp_axis.sv]
// one lateral axis: spread times signed offset, rounded divide by a constant, saturate
module dptcp_axis #(
    parameter int DEN    = 31,
    parameter int K_W    = 7,
    parameter int SIDE_W = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_valid,
    input  logic [dptcp_pkg::SPREAD_W-1:0]       i_spread,
    input  logic signed [K_W-1:0]                i_k,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic                                 o_valid,
    output logic signed [dptcp_pkg::COORD_W-1:0] o_coord,
    output logic [SIDE_W-1:0]                    o_side
);

    localparam int MAG_W  = K_W - 1;
    localparam int PROD_W = dptcp_pkg::SPREAD_W + MAG_W;
    localparam int NF_W   = PROD_W + 2;
    localparam int DW     = $clog2(2 * DEN + 1);
    localparam int QW     = dptcp_pkg::CQUO_W;
    localparam int NUM_W  = DW + QW;
    localparam int CW     = dptcp_pkg::COORD_W;
    // reciprocal of 2*DEN rounded up, exact floor for every numerator below 2^NUM_W
    localparam int     RSHIFT = NUM_W + $clog2(2 * DEN);
    localparam int     RCP_W  = NUM_W + 1;
    localparam int     RP_W   = NUM_W + RCP_W;
    localparam longint RCP    = ((longint'(1) << RSHIFT) + longint'(2 * DEN - 1))
                                / longint'(2 * DEN);
    localparam logic [RCP_W-1:0] RCP_V   = RCP_W'(RCP);
    localparam logic [NF_W-1:0]  BIG_LIM = NF_W'(2 * DEN) << QW;
    localparam logic [QW-1:0]    POS_MAX = QW'((1 << (CW - 1)) - 1);
    localparam logic [QW-1:0]    NEG_MAX = QW'(1 << (CW - 1));

    logic [MAG_W-1:0]  w_mag;
    logic [NF_W-1:0]   w_num_full;
    logic              w_big;
    logic [RP_W-1:0]   w_rprod;
    logic [QW-1:0]     w_neg_quo;

    logic              r_v1;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg1;
    logic [SIDE_W-1:0] r_side1;
    logic              r_v2;
    logic [NUM_W-1:0]  r_num;
    logic              r_big;
    logic              r_neg2;
    logic [SIDE_W-1:0] r_side2;
    logic              r_v3;
    logic [QW-1:0]     r_quo;
    logic              r_big3;
    logic              r_neg3;
    logic [SIDE_W-1:0] r_side3;
    logic              r_v4;
    logic signed [CW-1:0] r_coord;
    logic [SIDE_W-1:0] r_side4;

    // magnitude of the offset
    assign w_mag = i_k[K_W-1] ? MAG_W'(-i_k) : MAG_W'(i_k);

    // rounded numerator and early saturation check
    assign w_num_full = {r_prod, 1'b0} + NF_W'(DEN);
    assign w_big      = (w_num_full >= BIG_LIM);

    // divide by 2*DEN as a multiply by its reciprocal
    assign w_rprod   = RP_W'(r_num) * RP_W'(RCP_V);
    assign w_neg_quo = '0 - r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // multiply, numerator and reciprocal stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod  <= PROD_W'(i_spread) * PROD_W'(w_mag);
            r_neg1  <= i_k[K_W-1];
            r_side1 <= i_side;
            r_num   <= w_big ? '0 : NUM_W'(w_num_full);
            r_big   <= w_big;
            r_neg2  <= r_neg1;
            r_side2 <= r_side1;
            r_quo   <= w_rprod[RSHIFT +: QW];
            r_big3  <= r_big;
            r_neg3  <= r_neg2;
            r_side3 <= r_side2;
        end
    end

    // apply the sign and saturate to the coordinate range
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side4 <= r_side3;
            if (r_neg3) begin
                if (r_big3 || (r_quo > NEG_MAX)) begin
                    r_coord <= $signed(NEG_MAX);
                end else begin
                    r_coord <= $signed(w_neg_quo);
                end
            end else begin
                if (r_big3 || (r_quo > POS_MAX)) begin
                    r_coord <= $signed(POS_MAX);
                end else begin
                    r_coord <= $signed(r_quo);
                end
            end
        end
    end

    assign o_valid = r_v4;
    assign o_coord = r_coord;
    assign o_side  = r_side4;

endmodule

[rtl/dptcp_ramp.sv]
// four-segment jet color ramp over the nearness value
module dptcp_ramp (
    input  logic [dptcp_pkg::COLOR_W-1:0] i_near,
    output dptcp_pkg::t_color             o_color
);

    localparam logic [2:0] SEG_BLUE_CYAN    = 3'd0;
    localparam logic [2:0] SEG_CYAN_GREEN   = 3'd1;
    localparam logic [2:0] SEG_GREEN_YELLOW = 3'd2;
    localparam logic [2:0] SEG_YELLOW_RED   = 3'd3;
    localparam logic [2:0] SEG_RED_END      = 3'd4;

    logic [2:0]                    w_seg;
    logic [dptcp_pkg::COLOR_W-1:0] w_slope;

    // segment index and four times the offset into it
    assign w_seg   = i_near[12:10];
    assign w_slope = dptcp_pkg::COLOR_W'({i_near[9:0], 2'b00});

    always_comb begin
        o_color = '0;
        case (w_seg)
            SEG_BLUE_CYAN: begin
                o_color.color_green = w_slope;
                o_color.color_blue  = dptcp_pkg::COLOR_FULL;
            end
            SEG_CYAN_GREEN: begin
                o_color.color_green = dptcp_pkg::COLOR_FULL;
                o_color.color_blue  = dptcp_pkg::COLOR_FULL - w_slope;
            end
            SEG_GREEN_YELLOW: begin
                o_color.color_red   = w_slope;
                o_color.color_green = dptcp_pkg::COLOR_FULL;
            end
            SEG_YELLOW_RED: begin
                o_color.color_red   = dptcp_pkg::COLOR_FULL;
                o_color.color_green = dptcp_pkg::COLOR_FULL - w_slope;
            end
            SEG_RED_END: begin
                o_color.color_red   = dptcp_pkg::COLOR_FULL;
            end
            default: begin
                o_color = '0;
            end
        endcase
    end

endmodule

[tb/depth_pixel_to_colored_point_tb.sv]
// testbench for the depth pixel to colored point block, checked against its own point predictor
`timescale 1ns / 100ps

localparam int SENSOR_COLS = 32;
localparam int SENSOR_ROWS = 32;

// predicts the point of every accepted pixel with a nonzero depth and checks returned points in order
class point_cloud_scoreboard;
    bit [dptcp_pkg::DEPTH_W-1:0] max_depth;
    bit [dptcp_pkg::GAIN_W-1:0]  spread_gain;
    dptcp_pkg::t_point           expected_points[$];
    int                          failures;

    function new();
        max_depth   = dptcp_pkg::MAX_DEPTH_RST;
        spread_gain = dptcp_pkg::SPREAD_GAIN_RST;
        failures    = 0;
    endfunction

    // mirror of the register file, unknown indexes leave it alone
    function void write_register(logic [dptcp_pkg::CFG_IDX_W-1:0] idx,
                                 logic [dptcp_pkg::CFG_DATA_W-1:0] data);
        if (idx == dptcp_pkg::CFG_MAX_DEPTH) begin
            max_depth = data[dptcp_pkg::DEPTH_W-1:0];
        end else if (idx == dptcp_pkg::CFG_SPREAD_GAIN) begin
            spread_gain = data[dptcp_pkg::GAIN_W-1:0];
        end
    endfunction

    // integer division, halves rounded away from zero
    function longint divide_away(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (2 * mag + den) / (2 * den);
        return (num < 0) ? -mag : mag;
    endfunction

    // clamp to the signed Q3.12 range
    function logic signed [dptcp_pkg::COORD_W-1:0] clip_coord(longint v);
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[dptcp_pkg::COORD_W-1:0];
    endfunction

    function dptcp_pkg::t_point project_pixel(dptcp_pkg::t_pixel px);
        longint md;
        longint q;
        longint spread;
        longint near_v;
        longint col;
        longint row;
        dptcp_pkg::t_point pt;
        // normalized depth, halves rounded up, zero max_depth acts as one
        md     = (max_depth == 0) ? 1 : longint'(max_depth);
        q      = (longint'(px.depth_code) * 8192 + md) / (2 * md);
        spread = (longint'(spread_gain) * q * 2 + 4096) / 8192;
        col    = longint'(px.pixel_col);
        row    = longint'(px.pixel_row);
        // lateral coordinates scale the pixel position by the spread
        pt.point_x = clip_coord(divide_away(spread * (2 * col - (SENSOR_COLS - 1)),
                                            SENSOR_COLS - 1));
        pt.point_y = clip_coord(divide_away(spread * ((SENSOR_ROWS - 1) - 2 * row),
                                            SENSOR_ROWS - 1));
        pt.point_z = clip_coord(-((q > 32768) ? 32768 : q));
        // four segment jet ramp over nearness
        near_v = 4096 - ((q > 4096) ? 4096 : q);
        if (near_v < 1024) begin
            pt.color_red   = '0;
            pt.color_green = dptcp_pkg::COLOR_W'(4 * near_v);
            pt.color_blue  = dptcp_pkg::COLOR_FULL;
        end else if (near_v < 2048) begin
            pt.color_red   = '0;
            pt.color_green = dptcp_pkg::COLOR_FULL;
            pt.color_blue  = dptcp_pkg::COLOR_W'(4096 - 4 * (near_v - 1024));
        end else if (near_v < 3072) begin
            pt.color_red   = dptcp_pkg::COLOR_W'(4 * (near_v - 2048));
            pt.color_green = dptcp_pkg::COLOR_FULL;
            pt.color_blue  = '0;
        end else begin
            pt.color_red   = dptcp_pkg::COLOR_FULL;
            pt.color_green = dptcp_pkg::COLOR_W'(4096 - 4 * (near_v - 3072));
            pt.color_blue  = '0;
        end
        return pt;
    endfunction

    // a zero depth is dropped by the block
    function void note_pixel(dptcp_pkg::t_pixel px);
        if (px.depth_code != 0) begin
            expected_points.insert(expected_points.size(), project_pixel(px));
        end
    endfunction

    function void check_point(dptcp_pkg::t_point pt);
        dptcp_pkg::t_point exp_pt;
        if (expected_points.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("unexpected point x %0d y %0d z %0d rgb %0d %0d %0d",
                         pt.point_x, pt.point_y, pt.point_z,
                         pt.color_red, pt.color_green, pt.color_blue);
            end
        end else begin
            exp_pt = expected_points.pop_front();
            if (pt.point_x !== exp_pt.point_x || pt.point_y !== exp_pt.point_y ||
                pt.point_z !== exp_pt.point_z || pt.color_red !== exp_pt.color_red ||
                pt.color_green !== exp_pt.color_green ||
                pt.color_blue !== exp_pt.color_blue) begin
                failures++;
                if (failures <= 10) begin
                    $display("point mismatch exp x %0d y %0d z %0d rgb %0d %0d %0d",
                             exp_pt.point_x, exp_pt.point_y, exp_pt.point_z,
                             exp_pt.color_red, exp_pt.color_green, exp_pt.color_blue);
                    $display("               got x %0d y %0d z %0d rgb %0d %0d %0d",
                             pt.point_x, pt.point_y, pt.point_z,
                             pt.color_red, pt.color_green, pt.color_blue);
                end
            end
        end
    endfunction
endclass

module depth_pixel_to_colored_point_tb;

    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_POINTS = 105;
    localparam logic [dptcp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [dptcp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    dptcp_pkg::t_pixel                i_pixel;
    logic                             o_valid;
    logic                             i_stall;
    dptcp_pkg::t_point                o_point;
    logic                             i_cfg_we;
    logic [dptcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [dptcp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    point_cloud_scoreboard sb;
    bit                    hold_pending;
    int unsigned           cycle_count;

    depth_pixel_to_colored_point #(
        .SENSOR_COLS(SENSOR_COLS),
        .SENSOR_ROWS(SENSOR_ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_point    (o_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // both handshakes observed at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_pixel(i_pixel);
            end
            if (o_valid && !i_stall) begin
                sb.check_point(o_point);
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int span;
        int k;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            for (k = 0; k < span; k++) begin
                if (hold_pending) begin
                    hold_pending = 1'b0;
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= ($urandom_range(0, 3) == 0);
                    end
                    2: begin
                        i_stall <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        i_stall <= k[1];
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    // offer one request and hold it until taken
    task automatic send_pixel(dptcp_pkg::t_pixel px);
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_fields(int depth, int row, int col);
        dptcp_pkg::t_pixel px;
        px.depth_code = dptcp_pkg::DEPTH_W'(depth);
        px.pixel_row  = dptcp_pkg::PIXEL_W'(row);
        px.pixel_col  = dptcp_pkg::PIXEL_W'(col);
        send_pixel(px);
    endtask

    // cycles must be at least one so valid is not dropped and raised in one step
    task automatic pause_sender(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // idle until every point is back, then let dropped pixels leave the pipeline
    task automatic wait_for_points();
        i_valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [dptcp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [dptcp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    // spare indexes are poked first and must change nothing
    task automatic program_registers(logic [dptcp_pkg::CFG_DATA_W-1:0] depth_data,
                                     logic [dptcp_pkg::CFG_DATA_W-1:0] gain_data);
        write_register(CFG_SPARE_A, dptcp_pkg::CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_B, dptcp_pkg::CFG_DATA_W'($urandom));
        write_register(dptcp_pkg::CFG_MAX_DEPTH, depth_data);
        write_register(dptcp_pkg::CFG_SPREAD_GAIN, gain_data);
        i_cfg_we <= 1'b0;
    endtask

    // depth mostly around max_depth so all ramp segments show up
    function automatic dptcp_pkg::t_pixel random_pixel(logic [dptcp_pkg::DEPTH_W-1:0] md);
        dptcp_pkg::t_pixel px;
        int unsigned       top;
        top = (md == 0) ? 2 : 2 * int'(md);
        if (top > 65535) begin
            top = 65535;
        end
        case ($urandom_range(0, 11))
            0: begin
                px.depth_code = '0;
            end
            1: begin
                px.depth_code = dptcp_pkg::DEPTH_W'(1);
            end
            2: begin
                px.depth_code = '1;
            end
            3, 4: begin
                px.depth_code = dptcp_pkg::DEPTH_W'($urandom);
            end
            5: begin
                px.depth_code = (md == 0) ? dptcp_pkg::DEPTH_W'(1) : md;
            end
            default: begin
                px.depth_code = dptcp_pkg::DEPTH_W'($urandom_range(1, top));
            end
        endcase
        case ($urandom_range(0, 4))
            0: px.pixel_row = '0;
            1: px.pixel_row = dptcp_pkg::PIXEL_W'(dptcp_pkg::PIXEL_MAX);
            default: px.pixel_row = dptcp_pkg::PIXEL_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: px.pixel_col = '0;
            1: px.pixel_col = dptcp_pkg::PIXEL_W'(dptcp_pkg::PIXEL_MAX);
            default: px.pixel_col = dptcp_pkg::PIXEL_W'($urandom);
        endcase
        return px;
    endfunction

    // bursts of random pixels with random gaps; steady means no gaps at all
    task automatic run_pixels(int points, bit steady);
        int                sent;
        int                burst;
        dptcp_pkg::t_pixel px;
        sent = 0;
        while (sent < points) begin
            burst = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 32);
            repeat (burst) begin
                px = random_pixel(sb.max_depth);
                send_pixel(px);
                if (px.depth_code != 0) begin
                    sent++;
                end
            end
            if (!steady && $urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        int p;
        sb           = new();
        hold_pending = 1'b0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_pixel      = '0;
        i_stall      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, zero depth, far beyond max_depth
        send_fields(1, 0, 0);
        send_fields(65535, 31, 31);
        send_fields(8450, 0, 31);
        send_fields(8450, 31, 0);
        send_fields(0, 5, 5);
        send_fields(4225, 15, 16);
        send_fields(16900, 16, 15);
        send_fields(33800, 0, 0);
        wait_for_points();

        // unit scale so q equals depth: ramp segment edges and z saturation
        program_registers(16'd4096, 16'd4096);
        send_fields(4096, 0, 0);
        send_fields(3073, 0, 31);
        send_fields(3072, 31, 0);
        send_fields(3071, 15, 16);
        send_fields(2049, 16, 15);
        send_fields(2048, 0, 0);
        send_fields(2047, 31, 31);
        send_fields(1025, 7, 24);
        send_fields(1024, 24, 7);
        send_fields(1023, 0, 31);
        send_fields(1, 31, 0);
        send_fields(32768, 0, 31);
        send_fields(32769, 31, 31);
        send_fields(65535, 0, 0);
        send_fields(0, 31, 31);
        wait_for_points();

        // random phases over extreme and random settings
        for (p = 0; p < 7; p++) begin
            case (p)
                0: program_registers(16'd1, 16'd0);
                1: program_registers(16'd65535, 16'd4096);
                2: program_registers(16'd0, 16'hFFFF);
                3: program_registers(dptcp_pkg::MAX_DEPTH_RST,
                                     dptcp_pkg::CFG_DATA_W'(dptcp_pkg::SPREAD_GAIN_RST));
                4: program_registers(dptcp_pkg::CFG_DATA_W'($urandom_range(1, 64)),
                                     dptcp_pkg::CFG_DATA_W'($urandom_range(0, 4096)));
                5: program_registers(dptcp_pkg::CFG_DATA_W'($urandom_range(1, 65535)),
                                     dptcp_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                default: program_registers(dptcp_pkg::CFG_DATA_W'($urandom_range(256, 16384)),
                                           dptcp_pkg::CFG_DATA_W'($urandom_range(2048, 4096)));
            endcase
            if (p == 3) begin
                // receiver holds off while requests keep coming, filling the pipeline
                hold_pending = 1'b1;
                run_pixels(PHASE_POINTS, 1'b1);
            end else begin
                run_pixels(PHASE_POINTS, 1'b0);
            end
            wait_for_points();
        end

        if (sb.failures == 0 && sb.expected_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
